// ----- rtl/core/qtmf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Q-tensor molecular field block.
`default_nettype none
package qtmf_pkg;
	localparam logic signed [31:0] ONE_Q   = 32'sd268435456;
	localparam logic signed [31:0] THIRD_Q = 32'sd89478485;
	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;
	localparam logic [1:0] REG_A     = 2'd0;
	localparam logic [1:0] REG_U     = 2'd1;
	localparam logic [1:0] REG_KAPPA = 2'd2;

	typedef logic signed [31:0] q_t;

	// clamp a 40-bit signed value to 32 bits
	function automatic q_t sat40(input logic signed [39:0] v);
		q_t r;
		if (v > 40'sh007fffffff) r = SMAX;
		else if (v < -40'sh0080000000) r = SMIN;
		else r = v[31:0];
		return r;
	endfunction

	// round a 64-bit product half up to Q4.28 and saturate
	function automatic q_t rnd(input logic signed [63:0] p);
		logic signed [63:0] r;
		logic signed [35:0] s;
		q_t o;
		r = p + 64'sd134217728;
		s = r[63:28];
		if (s > 36'sh007fffffff) o = SMAX;
		else if (s < -36'sh0080000000) o = SMIN;
		else o = s[31:0];
		return o;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/qtensor_molecular_field.sv -----
// Top level: pipelined Landau-de Gennes molecular field of one bulk lattice point.
// One point per cycle; done strobes with each result once its start has passed seven register stages,
// each holding a row of 32x32 multipliers or a row of wide sums. busy is always low.
// The receiver cannot stall; every beat appears on the h ports for one cycle with done.
`default_nettype none
module qtensor_molecular_field (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic signed [31:0] q_xx, q_xy, q_xz, q_yy, q_yz,
	input  wire logic signed [31:0] nsum_xx, nsum_xy, nsum_xz, nsum_yy, nsum_yz,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [30:0] cfg_data,
	output logic             done,
	output logic signed [31:0] h_xx, h_xy, h_xz, h_yy, h_yz
);
	typedef logic signed [31:0] q_t;
	typedef logic signed [63:0] p_t;
	typedef logic signed [39:0] w_t;

	logic [30:0] a_q, u_q, k_q;
	q_t c1_q, c2_q;
	logic [6:0] v;

	assign busy = 1'b0;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 31'd268435456;
			u_q <= 31'd805306368;
			k_q <= 31'd268435456;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				qtmf_pkg::REG_A:     a_q <= cfg_data;
				qtmf_pkg::REG_U:     u_q <= cfg_data;
				qtmf_pkg::REG_KAPPA: k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// derive c1, c2 from registers (quasi-static: config to be written only when idle; the block does not enforce it)
	// (U + 1) / 3 by reciprocal multiplication, exact below 2^32
	logic [31:0] u1;
	logic [63:0] u3_prod;
	logic [30:0] u3_q;
	always_comb u1 = {1'b0, u_q} + 32'd1;
	always_comb u3_prod = {32'b0, u1} * 64'h00000000aaaaaaab;
	always_ff @(posedge clk) begin
		u3_q <= u3_prod[63:33];
		c1_q <= qtmf_pkg::rnd(p_t'($signed({1'b0, a_q})) *
			p_t'(w_t'(qtmf_pkg::ONE_Q) - w_t'($signed({1'b0, u3_q}))));
		c2_q <= qtmf_pkg::rnd(p_t'($signed({1'b0, a_q})) * p_t'($signed({1'b0, u_q})));
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else v <= {v[5:0], start};
	end

	// stage 1: zz and Laplacian
	q_t m_s1 [6];
	q_t l_s1 [5];
	always_ff @(posedge clk) begin
		m_s1[0] <= q_xx; m_s1[1] <= q_xy; m_s1[2] <= q_xz;
		m_s1[3] <= q_yy; m_s1[4] <= q_yz;
		m_s1[5] <= qtmf_pkg::sat40(-w_t'(q_xx) - w_t'(q_yy));
		l_s1[0] <= qtmf_pkg::sat40(w_t'(nsum_xx) - 40'sd6 * w_t'(q_xx));
		l_s1[1] <= qtmf_pkg::sat40(w_t'(nsum_xy) - 40'sd6 * w_t'(q_xy));
		l_s1[2] <= qtmf_pkg::sat40(w_t'(nsum_xz) - 40'sd6 * w_t'(q_xz));
		l_s1[3] <= qtmf_pkg::sat40(w_t'(nsum_yy) - 40'sd6 * w_t'(q_yy));
		l_s1[4] <= qtmf_pkg::sat40(w_t'(nsum_yz) - 40'sd6 * w_t'(q_yz));
	end

	// stage 2: products for trace and Q.Q
	// idx: 0 xx*xx 1 yy*yy 2 xx*yy 3 xy*xy 4 xz*xz 5 yz*yz 6 xx*xy 7 xy*yy
	// 8 xz*yz 9 xx*xz 10 xy*yz 11 xz*zz 12 xy*xz 13 yy*yz 14 yz*zz
	q_t pr_s2 [15];
	q_t m_s2 [6];
	q_t l_s2 [5];
	always_ff @(posedge clk) begin
		pr_s2[0]  <= qtmf_pkg::rnd(p_t'(m_s1[0]) * p_t'(m_s1[0]));
		pr_s2[1]  <= qtmf_pkg::rnd(p_t'(m_s1[3]) * p_t'(m_s1[3]));
		pr_s2[2]  <= qtmf_pkg::rnd(p_t'(m_s1[0]) * p_t'(m_s1[3]));
		pr_s2[3]  <= qtmf_pkg::rnd(p_t'(m_s1[1]) * p_t'(m_s1[1]));
		pr_s2[4]  <= qtmf_pkg::rnd(p_t'(m_s1[2]) * p_t'(m_s1[2]));
		pr_s2[5]  <= qtmf_pkg::rnd(p_t'(m_s1[4]) * p_t'(m_s1[4]));
		pr_s2[6]  <= qtmf_pkg::rnd(p_t'(m_s1[0]) * p_t'(m_s1[1]));
		pr_s2[7]  <= qtmf_pkg::rnd(p_t'(m_s1[1]) * p_t'(m_s1[3]));
		pr_s2[8]  <= qtmf_pkg::rnd(p_t'(m_s1[2]) * p_t'(m_s1[4]));
		pr_s2[9]  <= qtmf_pkg::rnd(p_t'(m_s1[0]) * p_t'(m_s1[2]));
		pr_s2[10] <= qtmf_pkg::rnd(p_t'(m_s1[1]) * p_t'(m_s1[4]));
		pr_s2[11] <= qtmf_pkg::rnd(p_t'(m_s1[2]) * p_t'(m_s1[5]));
		pr_s2[12] <= qtmf_pkg::rnd(p_t'(m_s1[1]) * p_t'(m_s1[2]));
		pr_s2[13] <= qtmf_pkg::rnd(p_t'(m_s1[3]) * p_t'(m_s1[4]));
		pr_s2[14] <= qtmf_pkg::rnd(p_t'(m_s1[4]) * p_t'(m_s1[5]));
		m_s2 <= m_s1;
		l_s2 <= l_s1;
	end

	// stage 3: trace, Q.Q sums, s terms
	q_t t_s3;
	q_t qq_s3 [5];
	q_t s_s3 [5];
	q_t m_s3 [5];
	q_t l_s3 [5];
	w_t tsum;
	always_comb tsum = w_t'(pr_s2[0]) + w_t'(pr_s2[1]) + w_t'(pr_s2[2]) + w_t'(pr_s2[3])
		+ w_t'(pr_s2[4]) + w_t'(pr_s2[5]);
	always_ff @(posedge clk) begin
		t_s3 <= qtmf_pkg::sat40(tsum <<< 1);
		qq_s3[0] <= qtmf_pkg::sat40(w_t'(pr_s2[0]) + w_t'(pr_s2[3]) + w_t'(pr_s2[4]));
		qq_s3[1] <= qtmf_pkg::sat40(w_t'(pr_s2[6]) + w_t'(pr_s2[7]) + w_t'(pr_s2[8]));
		qq_s3[2] <= qtmf_pkg::sat40(w_t'(pr_s2[9]) + w_t'(pr_s2[10]) + w_t'(pr_s2[11]));
		qq_s3[3] <= qtmf_pkg::sat40(w_t'(pr_s2[3]) + w_t'(pr_s2[1]) + w_t'(pr_s2[5]));
		qq_s3[4] <= qtmf_pkg::sat40(w_t'(pr_s2[12]) + w_t'(pr_s2[13]) + w_t'(pr_s2[14]));
		s_s3[0] <= qtmf_pkg::sat40(w_t'(m_s2[0]) + w_t'(qtmf_pkg::THIRD_Q));
		s_s3[1] <= m_s2[1];
		s_s3[2] <= m_s2[2];
		s_s3[3] <= qtmf_pkg::sat40(w_t'(m_s2[3]) + w_t'(qtmf_pkg::THIRD_Q));
		s_s3[4] <= m_s2[4];
		m_s3 <= m_s2[0:4];
		l_s3 <= l_s2;
	end

	// stage 4: t*s, c1*Q, kappa*L
	q_t ts_s4 [5], cq_s4 [5], kl_s4 [5], qq_s4 [5];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 5; c++) begin
			ts_s4[c] <= qtmf_pkg::rnd(p_t'(t_s3) * p_t'(s_s3[c]));
			cq_s4[c] <= qtmf_pkg::rnd(p_t'(c1_q) * p_t'(m_s3[c]));
			kl_s4[c] <= qtmf_pkg::rnd(p_t'($signed({1'b0, k_q})) * p_t'(l_s3[c]));
		end
		qq_s4 <= qq_s3;
	end

	// stage 5: inner
	q_t in_s5 [5], cq_s5 [5], kl_s5 [5];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 5; c++)
			in_s5[c] <= qtmf_pkg::sat40(w_t'(qq_s4[c]) - w_t'(ts_s4[c]));
		cq_s5 <= cq_s4;
		kl_s5 <= kl_s4;
	end

	// stage 6: c2*inner
	q_t ci_s6 [5], cq_s6 [5], kl_s6 [5];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 5; c++)
			ci_s6[c] <= qtmf_pkg::rnd(p_t'(c2_q) * p_t'(in_s5[c]));
		cq_s6 <= cq_s5;
		kl_s6 <= kl_s5;
	end

	// stage 7: combine and negate
	q_t h_s7 [5];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 5; c++)
			h_s7[c] <= qtmf_pkg::sat40(-w_t'(qtmf_pkg::sat40(w_t'(cq_s6[c])
				- w_t'(ci_s6[c]) - w_t'(kl_s6[c]))));
	end

	assign done = v[6];
	assign h_xx = h_s7[0];
	assign h_xy = h_s7[1];
	assign h_xz = h_s7[2];
	assign h_yy = h_s7[3];
	assign h_yz = h_s7[4];

	// every start yields a result beat
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##7 done) else $error("lost result beat");
	a_noinv: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7)) else $error("spurious result beat");
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> h_xx != qtmf_pkg::SMIN) else $error("negated sum reached minimum");
endmodule
`default_nettype wire

// ----- test/qtensor_molecular_field_tb.sv -----
// Self-checking testbench for the Q-tensor molecular field block.
`timescale 1ns / 1ps
module qtensor_molecular_field_tb;
	typedef qtmf_pkg::q_t q_t;

	localparam logic [1:0] REG_NONE = 2'd3;  // unmapped register index
	localparam int SETTLE = 12;             // cycles of quiet before a register write
	localparam int WATCHDOG = 2000;

	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [30:0] val;
		q_t         f[10];
	} op_t;

	typedef struct {
		q_t h[5];
	} field_t;

	logic clk, arst_n, start, cfg_we, done, busy;
	logic [1:0] cfg_idx;
	logic [30:0] cfg_data;
	q_t q_xx, q_xy, q_xz, q_yy, q_yz;
	q_t nsum_xx, nsum_xy, nsum_xz, nsum_yy, nsum_yz;
	q_t h_xx, h_xy, h_xz, h_yy, h_yz;

	op_t    pending_ops[$];
	field_t field_fifo[$];
	longint coef_a, coef_u, coef_kappa;
	int     gap_left, quiet_cycles, stall_cycles, errors;
	bit     calm;
	string  names[5] = '{"h_xx", "h_xy", "h_xz", "h_yy", "h_yz"};

	qtensor_molecular_field dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact product, round half up to Q4.28, saturate
	function automatic longint fxmul(input longint a, input longint b);
		longint r;
		r = a * b + (64'sd1 <<< 27);
		return clamp32(r >>> 28);
	endfunction

	function automatic field_t molecular_field(input q_t f[10]);
		int rows[5] = '{0, 0, 0, 1, 1};
		int cols[5] = '{0, 1, 2, 1, 2};
		longint q[5], lap[5], m[3][3];
		longint tr2, u3, c1, c2, qq, s, inner, term;
		field_t res;
		for (int c = 0; c < 5; c++) begin
			q[c] = f[c];
			lap[c] = clamp32(longint'(f[5+c]) - 6 * q[c]);
		end
		m[0][0] = q[0]; m[0][1] = q[1]; m[0][2] = q[2];
		m[1][0] = q[1]; m[1][1] = q[3]; m[1][2] = q[4];
		m[2][0] = q[2]; m[2][1] = q[4]; m[2][2] = clamp32(-q[0] - q[3]);
		tr2 = fxmul(q[0], q[0]) + fxmul(q[3], q[3]) + fxmul(q[0], q[3])
			+ fxmul(q[1], q[1]) + fxmul(q[2], q[2]) + fxmul(q[4], q[4]);
		tr2 = clamp32(2 * tr2);
		u3 = (coef_u + 1) / 3;
		c1 = fxmul(coef_a, longint'(qtmf_pkg::ONE_Q) - u3);
		c2 = fxmul(coef_a, coef_u);
		for (int c = 0; c < 5; c++) begin
			qq = 0;
			for (int k = 0; k < 3; k++) qq += fxmul(m[rows[c]][k], m[k][cols[c]]);
			qq = clamp32(qq);
			s = m[rows[c]][cols[c]];
			if (rows[c] == cols[c]) s = clamp32(s + longint'(qtmf_pkg::THIRD_Q));
			inner = clamp32(qq - fxmul(tr2, s));
			term = clamp32(fxmul(c1, m[rows[c]][cols[c]]) - fxmul(c2, inner)
				- fxmul(coef_kappa, lap[c]));
			res.h[c] = q_t'(clamp32(-term));
		end
		return res;
	endfunction

	// driver: one beat per queued point, register writes only once quiet
	always @(posedge clk or negedge arst_n) begin
		logic nxt_start, nxt_we;
		q_t   f[10];
		if (!arst_n) begin
			start <= 1'b0; cfg_we <= 1'b0; cfg_idx <= qtmf_pkg::REG_A; cfg_data <= '0;
			{q_xx, q_xy, q_xz, q_yy, q_yz} <= '0;
			{nsum_xx, nsum_xy, nsum_xz, nsum_yy, nsum_yz} <= '0;
			gap_left <= 0; quiet_cycles <= 0;
		end else begin
			nxt_start = start;
			nxt_we = 1'b0;
			if (start && !busy) begin
				f = '{q_xx, q_xy, q_xz, q_yy, q_yz,
					nsum_xx, nsum_xy, nsum_xz, nsum_yy, nsum_yz};
				field_fifo.push_back(molecular_field(f));
				nxt_start = 1'b0;
			end
			quiet_cycles <= (start || done) ? 0 : quiet_cycles + 1;
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_ops.size() > 0) begin
					if (pending_ops[0].is_cfg) begin
						if (!start && quiet_cycles >= SETTLE && field_fifo.size() == 0) begin
							nxt_we = 1'b1;
							cfg_idx <= pending_ops[0].idx;
							cfg_data <= pending_ops[0].val;
							case (pending_ops[0].idx)
								qtmf_pkg::REG_A:     coef_a = pending_ops[0].val;
								qtmf_pkg::REG_U:     coef_u = pending_ops[0].val;
								qtmf_pkg::REG_KAPPA: coef_kappa = pending_ops[0].val;
								default:   ;
							endcase
							void'(pending_ops.pop_front());
						end
					end else begin
						f = pending_ops[0].f;
						{q_xx, q_xy, q_xz, q_yy, q_yz} <= {f[0], f[1], f[2], f[3], f[4]};
						{nsum_xx, nsum_xy, nsum_xz, nsum_yy, nsum_yz} <=
							{f[5], f[6], f[7], f[8], f[9]};
						nxt_start = 1'b1;
						void'(pending_ops.pop_front());
						if ($urandom_range(0, 60) == 0) calm = !calm;
						gap_left <= calm ? 0 : $urandom_range(0, 4);
					end
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// monitor: check each result beat against the oldest prediction
	always @(posedge clk) begin
		field_t got, want;
		if (arst_n && done) begin
			got.h = '{h_xx, h_xy, h_xz, h_yy, h_yz};
			if (field_fifo.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				want = field_fifo.pop_front();
				for (int c = 0; c < 5; c++)
					if (got.h[c] !== want.h[c]) begin
						$error("%s: expected %0d, got %0d", names[c], want.h[c], got.h[c]);
						errors++;
					end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG) begin
			$display("qtensor_molecular_field verification failed");
			$finish;
		end
	end

	function automatic q_t rand_val(input int mode);
		case (mode)
			0: return q_t'($urandom);
			1: return q_t'(int'($urandom_range(0, 32'h3fffffff)) - 32'sh20000000);
			2: return ($urandom_range(0, 1)) ? qtmf_pkg::SMAX : qtmf_pkg::SMIN;
			default: return q_t'(int'($urandom_range(0, 32'h0fffffff)) - 32'sh08000000);
		endcase
	endfunction

	task automatic add_point(input q_t f[10]);
		op_t o;
		o.is_cfg = 1'b0; o.idx = qtmf_pkg::REG_A; o.val = '0; o.f = f;
		pending_ops.push_back(o);
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [30:0] val);
		op_t o;
		o.is_cfg = 1'b1; o.idx = idx; o.val = val; o.f = '{default: '0};
		pending_ops.push_back(o);
	endtask

	task automatic add_random_points(input int n);
		q_t f[10];
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			for (int c = 0; c < 10; c++)
				f[c] = rand_val(mode < 5 ? 3 : (mode < 8 ? 1 : ($urandom_range(0, 1) ? 0 : 2)));
			add_point(f);
		end
	endtask

	initial begin
		q_t third2;
		third2 = 32'sd178956970;
		arst_n = 1'b0;
		coef_a = 268435456; coef_u = 805306368; coef_kappa = 268435456;
		errors = 0; calm = 0; stall_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, extremes, uniaxial order, Laplacian only, mixed extremes, unit and tiny values
		add_point('{default: '0});
		add_point('{default: qtmf_pkg::SMAX});
		add_point('{default: qtmf_pkg::SMIN});
		add_point('{third2, 0, 0, -third2 / 2, 0, 0, 0, 0, 0, 0});
		add_point('{0, 0, 0, 0, 0, qtmf_pkg::SMAX, qtmf_pkg::SMIN, qtmf_pkg::SMAX,
			qtmf_pkg::SMIN, qtmf_pkg::SMAX});
		add_point('{qtmf_pkg::SMAX, qtmf_pkg::SMIN, qtmf_pkg::SMAX, qtmf_pkg::SMAX,
			qtmf_pkg::SMIN, 0, 0, 0, 0, 0});
		add_point('{qtmf_pkg::ONE_Q, qtmf_pkg::ONE_Q, qtmf_pkg::ONE_Q, qtmf_pkg::ONE_Q,
			qtmf_pkg::ONE_Q, 0, 0, 0, 0, 0});
		add_point('{-1, 1, -1, 1, -1, 32'sh55555555, -32'sh55555556, 1, -1, 0});
		add_random_points(150);

		// extremes of all coefficients, and an unmapped index that must be ignored
		add_write(qtmf_pkg::REG_A, '1); add_write(qtmf_pkg::REG_U, '1);
		add_write(qtmf_pkg::REG_KAPPA, '1);
		add_write(REG_NONE, '0);
		add_point('{third2, 0, 0, -third2 / 2, 0, 0, 0, 0, 0, 0});
		add_point('{default: qtmf_pkg::SMAX});
		add_random_points(150);
		add_write(qtmf_pkg::REG_A, '0); add_write(qtmf_pkg::REG_U, '0);
		add_write(qtmf_pkg::REG_KAPPA, '0);
		add_point('{default: qtmf_pkg::SMIN});
		add_random_points(100);

		// random coefficient settings
		for (int p = 0; p < 5; p++) begin
			add_write(qtmf_pkg::REG_A, $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 4));
			add_write(qtmf_pkg::REG_U, $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 4));
			add_write(qtmf_pkg::REG_KAPPA,
				$urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 4));
			add_random_points(160);
		end

		// drain and settle
		wait (pending_ops.size() == 0 && !start && field_fifo.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("qtensor_molecular_field verification clean");
		else
			$display("qtensor_molecular_field verification failed");
		$finish;
	end
endmodule
